[rtl/dsort_pkg.sv]
// shared types and constants of the descending insertion sorter
`timescale 1ns / 1ps
`default_nettype none

package dsort_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned PAYLOAD_W    = 64;

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  // commands from the controller to the cell chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/dsort_cell.sv]
// one cell of the insertion chain: holds a record, inserts or shifts
`timescale 1ns / 1ps
`default_nettype none

module dsort_cell (
  input  wire                  clk_i,
  input  dsort_pkg::cmd_t      cmd_i,
  input  wire                  occupied_i,
  input  dsort_pkg::key_t      new_key_i,
  input  dsort_pkg::payload_t  new_payload_i,
  input  wire                  prev_ahead_i,
  input  dsort_pkg::key_t      prev_key_i,
  input  dsort_pkg::payload_t  prev_payload_i,
  input  dsort_pkg::key_t      next_key_i,
  input  dsort_pkg::payload_t  next_payload_i,
  output logic                 ahead_o,
  output dsort_pkg::key_t      key_o,
  output dsort_pkg::payload_t  payload_o
);
  import dsort_pkg::*;

  key_t     key_q, key_d;
  payload_t payload_q, payload_d;

  // stored record stays ahead unless the new key is strictly larger
  assign ahead_o = occupied_i && !(new_key_i > key_q);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (cmd_i.shift) begin
      key_d     = next_key_i;
      payload_d = next_payload_i;
    end else if (cmd_i.insert && !ahead_o) begin
      if (prev_ahead_i) begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end else begin
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

[rtl/dsort_datapath.sv]
// insertion chain of record cells, head cell drives the result
`timescale 1ns / 1ps
`default_nettype none

module dsort_datapath #(
  parameter int unsigned CAPACITY = dsort_pkg::CAPACITY_DEF,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dsort_pkg::cmd_t      cmd_i,
  input  wire [CW-1:0]         fill_i,
  input  dsort_pkg::key_t      new_key_i,
  input  dsort_pkg::payload_t  new_payload_i,
  output dsort_pkg::key_t      head_key_o,
  output dsort_pkg::payload_t  head_payload_o
);
  import dsort_pkg::*;

  key_t     key_w     [CAPACITY];
  payload_t payload_w [CAPACITY];
  logic     ahead_w   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic     prev_ahead;
    key_t     prev_key, next_key;
    payload_t prev_payload, next_payload;

    if (i == 0) begin : g_head
      assign prev_ahead   = 1'b1;
      assign prev_key     = new_key_i;
      assign prev_payload = new_payload_i;
    end else begin : g_body
      assign prev_ahead   = ahead_w[i-1];
      assign prev_key     = key_w[i-1];
      assign prev_payload = payload_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key     = key_w[i];
      assign next_payload = payload_w[i];
    end else begin : g_mid
      assign next_key     = key_w[i+1];
      assign next_payload = payload_w[i+1];
    end

    dsort_cell u_cell (
      .clk_i          (clk_i),
      .cmd_i          (cmd_i),
      .occupied_i     (fill_i > CW'(i)),
      .new_key_i      (new_key_i),
      .new_payload_i  (new_payload_i),
      .prev_ahead_i   (prev_ahead),
      .prev_key_i     (prev_key),
      .prev_payload_i (prev_payload),
      .next_key_i     (next_key),
      .next_payload_i (next_payload),
      .ahead_o        (ahead_w[i]),
      .key_o          (key_w[i]),
      .payload_o      (payload_w[i])
    );
  end

  assign head_key_o     = key_w[0];
  assign head_payload_o = payload_w[0];

  // occupied cells stay in descending key order
  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (fill_i > CW'(i + 1)) |-> (key_w[i] >= key_w[i+1]))
      else $error("chain out of order");
  end

endmodule

`default_nettype wire

[rtl/dsort_ctrl.sv]
// controller: load and emit phases, fill count and overflow flag
`timescale 1ns / 1ps
`default_nettype none

module dsort_ctrl #(
  parameter int unsigned CAPACITY = dsort_pkg::CAPACITY_DEF,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              last_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic             out_last_o,
  output logic             overflowed_o,
  output dsort_pkg::cmd_t  cmd_o,
  output logic [CW-1:0]    fill_o
);
  import dsort_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          drop_q, drop_d;
  logic          in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
    end
  end

  // input stall is low throughout load and output valid high throughout emit
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    drop_d       = drop_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (fill_q < CW'(CAPACITY)) begin
            cmd_o.insert = 1'b1;
            fill_d       = fill_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.shift = 1'b1;
          fill_d      = fill_q - CW'(1);
          if (fill_q == CW'(1)) begin
            drop_d  = 1'b0;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign out_last_o   = (fill_q == CW'(1));
  assign overflowed_o = drop_q;
  assign fill_o       = fill_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q != '0))
    else $error("emitting from an empty chain");

  a_last_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_i) |=> out_valid_o)
    else $error("last record did not start emission");

  a_batch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_o) |=> (fill_q == '0 && !drop_q && !in_stall_o))
    else $error("batch state not cleared after final transfer");

endmodule

`default_nettype wire

[rtl/descending_insertion_sorter_core.sv]
// top level of the stable descending insertion sorter
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  input   | in        | in_valid_i / in_stall_o | score_i, payload_i, last_i
//  output  | out       | out_valid_o/out_stall_i | out_score_o, out_payload_o, out_last_o,
//          |           |                        | overflowed_o
//
// a record that is not last goes straight into the chain (dropped when it is full): every cell
//   compares its key with the new one at once and inserts or shifts in the same cycle
// a last record is loaded the same way, and from the next cycle the batch leaves one record per
//   cycle from the head cell when nothing stalls
// input is stalled for the whole emission; output stall freezes the head cell
// reset clears the phase, fill count and overflow flag; cell contents need no reset
`timescale 1ns / 1ps
`default_nettype none

module descending_insertion_sorter_core #(
  parameter int unsigned CAPACITY = dsort_pkg::CAPACITY_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input channel
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  dsort_pkg::key_t      score_i,
  input  dsort_pkg::payload_t  payload_i,
  input  wire                  last_i,
  // output channel
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output dsort_pkg::key_t      out_score_o,
  output dsort_pkg::payload_t  out_payload_o,
  output logic                 out_last_o,
  output logic                 overflowed_o
);
  import dsort_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cmd_t          cmd;
  logic [CW-1:0] fill;

  // phase control, fill count and sticky overflow
  dsort_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_i       (last_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_last_o   (out_last_o),
    .overflowed_o (overflowed_o),
    .cmd_o        (cmd),
    .fill_o       (fill)
  );

  // sorted record chain; the head cell doubles as the output register
  dsort_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .fill_i         (fill),
    .new_key_i      (score_i),
    .new_payload_i  (payload_i),
    .head_key_o     (out_score_o),
    .head_payload_o (out_payload_o)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench of the stable descending insertion sorter
`timescale 1ns / 1ps

module testbench;

  import dsort_pkg::*;

  localparam int unsigned DEPTH          = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS   = 100;
  localparam int          PHASE_ITEMS    = 10;    // random items per idling phase
  localparam int          HOLD_CYCLES    = 250;   // long receiver hold-off
  localparam int          WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int          DRAIN_CYCLES   = DEPTH + 16;
  localparam int          MAX_REPORTS    = 10;

  // one emitted record as seen on the output channel
  typedef struct packed {
    key_t     score;
    payload_t data;
    logic     last;
    logic     ovf;
  } sorted_rec_t;

  // directed row: reps > 1 loads a run of records, key stepping by step and payload
  // counting up, with last only on the final one; want is used where known is set
  typedef struct packed {
    key_t        score;
    payload_t    data;
    logic        last;
    int          reps;
    key_t        step;
    logic        known;
    sorted_rec_t want;
  } stim_row_t;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_BOTH_IDLE,
    PH_BACKPRESSURE
  } phase_e;

  typedef enum int {
    KEYS_TIED,
    KEYS_FULL,
    KEYS_EXTREME
  } key_mix_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  key_t     score_i     = '0;
  payload_t payload_i   = '0;
  logic     last_i      = 1'b0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  key_t     out_score_o;
  payload_t out_payload_o;
  logic     out_last_o;
  logic     overflowed_o;

  // predictor state: the sorted store as it should be after every accepted record
  key_t        held_key  [DEPTH];
  payload_t    held_data [DEPTH];
  int          held_cnt   = 0;
  logic        dropped    = 1'b0;
  sorted_rec_t sorted_q[$];

  phase_e phase     = PH_STEADY;
  bit     hold_req  = 1'b0;
  int     hold_left = 0;
  int     err_cnt   = 0;
  int     quiet_cnt = 0;

  stim_row_t directed_rows [22] = '{
    // single-record batches straight after reset: the record comes back alone
    '{16'h0000, 64'h0, 1'b1, 1, 16'h0, 1'b1, '{16'h0000, 64'h0, 1'b1, 1'b0}},
    '{16'hFFFF, '1, 1'b1, 1, 16'h0, 1'b1, '{16'hFFFF, '1, 1'b1, 1'b0}},
    '{16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1, 16'h0, 1'b1,
      '{16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0}},
    '{16'hAAAA, 64'h5555_5555_5555_5555, 1'b1, 1, 16'h0, 1'b1,
      '{16'hAAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b0}},
    // ascending load comes out reversed
    '{16'h0001, 64'h11, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h0002, 64'h12, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h0003, 64'h13, 1'b1, 1, 16'h0, 1'b0, '0},
    // ties keep load order, key extremes late in a batch
    '{16'h0007, 64'h21, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h0007, 64'h22, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h0009, 64'h23, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h0007, 64'h24, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'hFFFF, 64'h25, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h0000, 64'h26, 1'b1, 1, 16'h0, 1'b0, '0},
    // keys around the top bit, unsigned compare
    '{16'h8000, 64'h31, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h7FFF, 64'h32, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'h8001, 64'h33, 1'b1, 1, 16'h0, 1'b0, '0},
    // store filled exactly
    '{16'h0400, 64'hC000_0000_0000_0000, 1'b1, 64, 16'hF00D, 1'b0, '0},
    // store full with equal keys, then full with the last record itself dropped
    '{16'h00AA, 64'h0D00, 1'b1, 70, 16'h0, 1'b0, '0},
    '{16'h0001, 64'h0E00, 1'b1, 65, 16'h1, 1'b0, '0},
    // overflow flag must not leak into the next batch
    '{16'h0003, 64'hBEEF, 1'b1, 1, 16'h0, 1'b1, '{16'h0003, 64'hBEEF, 1'b1, 1'b0}},
    '{16'hFFFF, 64'h0, 1'b0, 1, 16'h0, 1'b0, '0},
    '{16'hFFFF, 64'h1, 1'b1, 1, 16'h0, 1'b0, '0}
  };

  descending_insertion_sorter_core #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .score_i      (score_i),
    .payload_i    (payload_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_score_o  (out_score_o),
    .out_payload_o(out_payload_o),
    .out_last_o   (out_last_o),
    .overflowed_o (overflowed_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // insert one record into the predicted store; on last, emit the batch best first
  function automatic void sort_in(key_t k, payload_t d, logic lst, bit publish);
    int slot;
    sorted_rec_t rec;
    if (held_cnt < DEPTH) begin
      slot = 0;
      // stable: pass every held key that is not strictly smaller
      while (slot < held_cnt && !(k > held_key[slot])) slot++;
      for (int j = held_cnt; j > slot; j--) begin
        held_key[j]  = held_key[j-1];
        held_data[j] = held_data[j-1];
      end
      held_key[slot]  = k;
      held_data[slot] = d;
      held_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (lst) begin
      for (int j = 0; j < held_cnt; j++) begin
        rec.score = held_key[j];
        rec.data  = held_data[j];
        rec.last  = (j == held_cnt - 1);
        rec.ovf   = dropped;
        if (publish) sorted_q.push_back(rec);
      end
      held_cnt = 0;
      dropped  = 1'b0;
    end
  endfunction

  function automatic int send_gap_pct();
    case (phase)
      PH_SENDER_GAPS: return 76;
      PH_BOTH_IDLE:   return 11;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (phase)
      PH_RECEIVER_STALLS: return 76;
      PH_BOTH_IDLE:       return 11;
      default:            return 0;
    endcase
  endfunction

  function automatic key_t draw_key(key_mix_e mix);
    case (mix)
      KEYS_TIED: return key_t'($urandom_range(0, 7));
      KEYS_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          2:       return 16'h8000;
          3:       return 16'h7FFF;
          default: return key_t'($urandom);
        endcase
      end
      default: return key_t'($urandom);
    endcase
  endfunction

  // offer one record, hold it until the transfer, then predict at that edge
  task automatic offer_record(input key_t k, input payload_t d, input logic lst,
                              input logic known, input sorted_rec_t want);
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    score_i    <= k;
    payload_i  <= d;
    last_i     <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sort_in(k, d, lst, !known);
    if (known) sorted_q.push_back(want);
  endtask

  // receiver: random stalls per phase, or one long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      out_stall_i <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_req  = 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  // output check against the oldest expected record, plus the watchdog
  always @(posedge clk_i) begin
    sorted_rec_t got;
    sorted_rec_t exp_rec;
    bit in_xfer;
    bit out_xfer;
    in_xfer  = rst_ni && in_valid_i && in_stall_o === 1'b0;
    out_xfer = rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0;
    if (out_xfer) begin
      got = '{out_score_o, out_payload_o, out_last_o, overflowed_o};
      if (sorted_q.size() == 0) begin
        if (err_cnt < MAX_REPORTS)
          $display("unexpected transfer: score %h payload %h last %b ovf %b",
                   got.score, got.data, got.last, got.ovf);
        err_cnt++;
      end else begin
        exp_rec = sorted_q.pop_front();
        if (got.score !== exp_rec.score || got.data !== exp_rec.data ||
            got.last !== exp_rec.last || got.ovf !== exp_rec.ovf) begin
          if (err_cnt < MAX_REPORTS)
            $display({"mismatch: expected score %h payload %h last %b ovf %b, ",
                      "got score %h payload %h last %b ovf %b"},
                     exp_rec.score, exp_rec.data, exp_rec.last, exp_rec.ovf,
                     got.score, got.data, got.last, got.ovf);
          err_cnt++;
        end
      end
    end
    if (in_xfer || out_xfer) quiet_cnt = 0;
    else quiet_cnt = quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int          rand_items;
    int          batch_len;
    int          roll;
    phase_e      next_phase;
    key_mix_e    mix;
    stim_row_t   row;
    sorted_rec_t none;
    rand_items = 0;
    none       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int i = 0; i < row.reps; i++)
        offer_record(key_t'(row.score + i * row.step), row.data + payload_t'(i),
                     row.last && (i == row.reps - 1), row.known, row.want);
    end

    // random batches; idling phase rotates with the item count, each phase twice
    while (rand_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      batch_len = $urandom_range(1, 8);
      else if (roll < 90) batch_len = $urandom_range(9, 40);
      else                batch_len = $urandom_range(60, 72);  // around and past full
      if (batch_len > RANDOM_ITEMS - rand_items) batch_len = RANDOM_ITEMS - rand_items;
      mix = key_mix_e'($urandom_range(0, 2));
      for (int i = 0; i < batch_len; i++) begin
        next_phase = phase_e'((rand_items / PHASE_ITEMS) % 5);
        if (next_phase != phase && next_phase == PH_BACKPRESSURE) hold_req = 1'b1;
        phase = next_phase;
        offer_record(draw_key(mix), {$urandom, $urandom}, i == batch_len - 1,
                     1'b0, none);
        rand_items++;
      end
    end
    in_valid_i <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && sorted_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
